@@ sv/pmt_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet tracker.
// Used by every module of the block; depends on nothing.
package pmt_pkg;

  localparam int RX_W       = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;

  // Reset values of the limits and of the pointer.
  localparam int X_LIMIT_RESET  = 1280;
  localparam int Y_LIMIT_RESET  = 720;
  localparam int CURSOR_X_RESET = 640;
  localparam int CURSOR_Y_RESET = 360;

  // Bit positions within the packet header byte.
  localparam int HDR_LEFT_BIT  = 0;
  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  // Position of the next byte within a three-byte packet.
  typedef enum logic [1:0] {
    SLOT_HDR = 2'd0,
    SLOT_DX  = 2'd1,
    SLOT_DY  = 2'd2
  } slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LIMIT = 1'b0,
    REG_Y_LIMIT = 1'b1
  } cfg_reg_t;

  // A received byte held in the input register.
  typedef struct packed {
    logic            valid;
    logic [RX_W-1:0] data;
  } rx_item_t;

endpackage

@@ sv/pmt_in_stage.sv @@
// Input register of the packet tracker: holds one received byte.
// Depends on pmt_pkg.
module pmt_in_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [pmt_pkg::RX_W-1:0] s_tdata,
  input  logic                   take,
  output pmt_pkg::rx_item_t      item
);

  logic                     in_valid;
  logic [pmt_pkg::RX_W-1:0] in_byte;

  // The register frees up in the same cycle that the tracker consumes it.
  assign s_tready   = !rst && (!in_valid || take);
  assign item.valid = in_valid;
  assign item.data  = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

endmodule

@@ sv/pmt_tracker.sv @@
// Packet framing, pointer update with clamping, and the result register.
// Depends on pmt_pkg.
module pmt_tracker #(
  parameter int POS_WIDTH = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pmt_pkg::rx_item_t    item,
  output logic                 take,
  input  logic [POS_WIDTH-1:0] x_limit,
  input  logic [POS_WIDTH-1:0] y_limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_WIDTH-1:0] pos_x,
  output logic [POS_WIDTH-1:0] pos_y,
  output logic                 left_held,
  output logic                 left_click
);

  localparam int SUM_W = POS_WIDTH + 2;

  pmt_pkg::slot_t           slot;
  pmt_pkg::slot_t           slot_next;
  logic [pmt_pkg::RX_W-1:0] header_byte;
  logic [pmt_pkg::RX_W-1:0] dx_byte;
  logic [POS_WIDTH-1:0]     cursor_x;
  logic [POS_WIDTH-1:0]     cursor_y;
  logic [POS_WIDTH-1:0]     cursor_x_next;
  logic [POS_WIDTH-1:0]     cursor_y_next;
  logic                     button_prev;
  logic                     click;
  logic                     completes;

  logic signed [SUM_W-1:0] dx_ext;
  logic signed [SUM_W-1:0] dy_ext;
  logic signed [SUM_W-1:0] nx;
  logic signed [SUM_W-1:0] ny;

  // Slot sequencing. A byte without the sync bit never starts a packet.
  always_comb begin
    slot_next = slot;
    case (slot)
      pmt_pkg::SLOT_DX: slot_next = pmt_pkg::SLOT_DY;
      pmt_pkg::SLOT_DY: slot_next = pmt_pkg::SLOT_HDR;
      default: begin
        if (item.data[pmt_pkg::HDR_SYNC_BIT]) begin
          slot_next = pmt_pkg::SLOT_DX;
        end else begin
          slot_next = pmt_pkg::SLOT_HDR;
        end
      end
    endcase
  end

  // Only the last byte of a packet needs room in the result register.
  assign completes = (slot == pmt_pkg::SLOT_DY);
  assign take      = item.valid && (!completes || !out_valid || out_ready);

  // Nine-bit deltas, sign from the header, widened to the sum width.
  always_comb begin
    dx_ext = signed'({{(SUM_W-pmt_pkg::RX_W){header_byte[pmt_pkg::HDR_XSIGN_BIT]}}, dx_byte});
    dy_ext = signed'({{(SUM_W-pmt_pkg::RX_W){header_byte[pmt_pkg::HDR_YSIGN_BIT]}},
                      item.data});
    nx     = signed'({2'b00, cursor_x}) + dx_ext;
    ny     = signed'({2'b00, cursor_y}) - dy_ext;
  end

  always_comb begin
    if (nx[SUM_W-1]) begin
      cursor_x_next = '0;
    end else if (nx > signed'({2'b00, x_limit})) begin
      cursor_x_next = x_limit;
    end else begin
      cursor_x_next = nx[POS_WIDTH-1:0];
    end
    if (ny[SUM_W-1]) begin
      cursor_y_next = '0;
    end else if (ny > signed'({2'b00, y_limit})) begin
      cursor_y_next = y_limit;
    end else begin
      cursor_y_next = ny[POS_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot        <= pmt_pkg::SLOT_HDR;
      header_byte <= '0;
      dx_byte     <= '0;
      cursor_x    <= POS_WIDTH'(pmt_pkg::CURSOR_X_RESET);
      cursor_y    <= POS_WIDTH'(pmt_pkg::CURSOR_Y_RESET);
      button_prev <= 1'b0;
      click       <= 1'b0;
    end else begin
      if (take) begin
        slot <= slot_next;
        case (slot)
          pmt_pkg::SLOT_DX: dx_byte <= item.data;
          pmt_pkg::SLOT_DY: begin
            cursor_x    <= cursor_x_next;
            cursor_y    <= cursor_y_next;
            button_prev <= header_byte[pmt_pkg::HDR_LEFT_BIT];
            click       <= header_byte[pmt_pkg::HDR_LEFT_BIT] & ~button_prev;
          end
          default: begin
            if (item.data[pmt_pkg::HDR_SYNC_BIT]) begin
              header_byte <= item.data;
            end
          end
        endcase
      end
    end
  end

  // A loaded result stays until it is transferred; a new one may load in the
  // same cycle that the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && completes) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The pointer registers change only when a result is loaded, so they
  // double as the result payload.
  assign pos_x      = cursor_x;
  assign pos_y      = cursor_y;
  assign left_held  = button_prev;
  assign left_click = click;

endmodule

@@ sv/ps2_mouse_packet_tracker_core.sv @@
// Top level of the PS/2 mouse packet tracker: limit registers and stream ports.
// Depends on pmt_pkg, pmt_in_stage and pmt_tracker.
//
// Received mouse bytes enter on the s_* stream, one byte per transfer. Bytes
// are framed into three-byte packets (header, X delta, Y delta); while a
// header is awaited, a byte with bit 3 clear is dropped. Each completed
// packet moves the pointer by the signed deltas (Y inverted), clamps it to
// the range from zero to x_limit and y_limit, and sends one result on the
// m_* stream with the position, the left button level and a click pulse on
// the button's press.
// The last packet byte goes through the input register and then loads the
// result register, which raises m_tvalid. One byte is taken every cycle: the
// input register and the result register stand apart, so bytes keep flowing
// while a result waits. When the receiver stalls, a finished result holds;
// header and X bytes are still taken, and only the Y byte of the next packet
// waits. Reset clears the framing state, sets the pointer to (640, 360),
// restores the limits to 1280 and 720, empties both registers and holds
// s_tready low. The user writes the limits through cfg_wen, cfg_index and
// cfg_data only while idle; the block itself does not enforce this.
module ps2_mouse_packet_tracker_core #(
  parameter int POS_WIDTH = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: rx_byte[7:0]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pmt_pkg::RX_W-1:0]         s_tdata,
  // m_tdata: pos_x, pos_y, left_held, left_click, zero fill to whole bytes
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [((2*POS_WIDTH+2+7)/8)*8-1:0] m_tdata,
  input  logic                             cfg_wen,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int OUT_W = ((2*POS_WIDTH+2+7)/8)*8;

  pmt_pkg::rx_item_t    item;
  logic                 take;
  logic [POS_WIDTH-1:0] x_limit;
  logic [POS_WIDTH-1:0] y_limit;
  logic [POS_WIDTH-1:0] pos_x;
  logic [POS_WIDTH-1:0] pos_y;
  logic                 left_held;
  logic                 left_click;

  // Limits keep the low POS_WIDTH bits of the 12-bit register value.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= POS_WIDTH'(pmt_pkg::X_LIMIT_RESET);
      y_limit <= POS_WIDTH'(pmt_pkg::Y_LIMIT_RESET);
    end else if (cfg_wen) begin
      case (pmt_pkg::cfg_reg_t'(cfg_index))
        pmt_pkg::REG_X_LIMIT: x_limit <= POS_WIDTH'(cfg_data);
        pmt_pkg::REG_Y_LIMIT: y_limit <= POS_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  pmt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .item     (item)
  );

  pmt_tracker #(
    .POS_WIDTH (POS_WIDTH)
  ) u_trk (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (take),
    .x_limit    (x_limit),
    .y_limit    (y_limit),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .left_held  (left_held),
    .left_click (left_click)
  );

  // Fields packed from the lowest bit up; the zero fill sits above them.
  assign m_tdata = OUT_W'({left_click, left_held, pos_y, pos_x});

endmodule

@@ sv/pmt_checker.sv @@
// Port-level checks for the PS/2 mouse packet tracker, bound to the top level.
// Depends on pmt_pkg and ps2_mouse_packet_tracker_core.
module pmt_checker #(
  parameter int POS_WIDTH = 12
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [pmt_pkg::RX_W-1:0]         s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [((2*POS_WIDTH+2+7)/8)*8-1:0] m_tdata,
  input logic                             cfg_wen,
  input logic [pmt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [pmt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int HELD_BIT  = 2*POS_WIDTH;
  localparam int CLICK_BIT = 2*POS_WIDTH + 1;

  // Left button level of the last result that was transferred.
  logic prev_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_held <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      prev_held <= m_tdata[HELD_BIT];
    end
  end

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A click is only ever reported together with the button held.
  a_click_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[CLICK_BIT] || m_tdata[HELD_BIT]))
    else $error("click without button held");

  // A click needs the previous result to have shown the button released.
  a_click_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[CLICK_BIT] |-> !prev_held)
    else $error("click reported while button was already held");

  // Input stays closed during reset.
  a_no_input_in_reset: assert property (@(posedge clk) rst |-> !s_tready)
    else $error("input transfer possible during reset");

endmodule

bind ps2_mouse_packet_tracker_core pmt_checker #(.POS_WIDTH(POS_WIDTH)) u_chk (.*);

@@ verif/pmt_pointer_checker.sv @@
// Checker for the PS/2 mouse packet tracker: watches the byte, result and limit ports,
// tracks packet framing and the pointer, and compares every result transfer.
// Depends on pmt_pkg for the slot and register codes and the reset values.
module pmt_pointer_checker #(
  parameter int POS_W   = 12,
  parameter int TDATA_W = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [pmt_pkg::RX_W-1:0]       s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [TDATA_W-1:0]             m_tdata,
  input  logic                           cfg_wen,
  input  logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             held;
    logic             click;
  } move_t;

  pmt_pkg::slot_t           frame_slot;
  logic [pmt_pkg::RX_W-1:0] hdr_q;
  logic [pmt_pkg::RX_W-1:0] dx_q;
  logic [POS_W-1:0]         ptr_x;
  logic [POS_W-1:0]         ptr_y;
  logic [POS_W-1:0]         lim_x;
  logic [POS_W-1:0]         lim_y;
  logic                     left_prev;
  move_t                    expected_moves[$];

  task automatic note_mismatch(input string what, input longint got, input longint want);
    fail_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic logic [POS_W-1:0] clamp_to(input int v, input logic [POS_W-1:0] lim);
    if (v < 0) return '0;
    if (v > int'(lim)) return lim;
    return POS_W'(v);
  endfunction

  // Frames one received byte; a Y byte closes the packet and queues the move it causes.
  task automatic track_rx_byte(input logic [pmt_pkg::RX_W-1:0] b);
    int    dx;
    int    dy;
    move_t mv;
    case (frame_slot)
      pmt_pkg::SLOT_DX: begin
        dx_q       = b;
        frame_slot = pmt_pkg::SLOT_DY;
      end
      pmt_pkg::SLOT_DY: begin
        frame_slot = pmt_pkg::SLOT_HDR;
        dx         = int'(dx_q) - (hdr_q[pmt_pkg::HDR_XSIGN_BIT] ? 256 : 0);
        dy         = int'(b) - (hdr_q[pmt_pkg::HDR_YSIGN_BIT] ? 256 : 0);
        ptr_x      = clamp_to(int'(ptr_x) + dx, lim_x);
        ptr_y      = clamp_to(int'(ptr_y) - dy, lim_y);
        mv.pos_x   = ptr_x;
        mv.pos_y   = ptr_y;
        mv.held    = hdr_q[pmt_pkg::HDR_LEFT_BIT];
        mv.click   = mv.held && !left_prev;
        left_prev  = mv.held;
        expected_moves.push_back(mv);
      end
      default: begin
        if (b[pmt_pkg::HDR_SYNC_BIT]) begin
          hdr_q      = b;
          frame_slot = pmt_pkg::SLOT_DX;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    move_t want;
    if (rst) begin
      frame_slot = pmt_pkg::SLOT_HDR;
      hdr_q      = '0;
      dx_q       = '0;
      ptr_x      = POS_W'(pmt_pkg::CURSOR_X_RESET);
      ptr_y      = POS_W'(pmt_pkg::CURSOR_Y_RESET);
      lim_x      = POS_W'(pmt_pkg::X_LIMIT_RESET);
      lim_y      = POS_W'(pmt_pkg::Y_LIMIT_RESET);
      left_prev  = 1'b0;
      expected_moves.delete();
    end else begin
      if (cfg_wen) begin
        case (pmt_pkg::cfg_reg_t'(cfg_index))
          pmt_pkg::REG_X_LIMIT: lim_x = POS_W'(cfg_data);
          pmt_pkg::REG_Y_LIMIT: lim_y = POS_W'(cfg_data);
          default: ;
        endcase
      end
      // A result leaves only after its Y byte has passed the input and result registers, so popping first is safe.
      if (m_tvalid && m_tready) begin
        if (expected_moves.size() == 0) begin
          note_mismatch("result with none pending", m_tdata, 0);
        end else begin
          want = expected_moves.pop_front();
          if (m_tdata[POS_W-1:0] !== want.pos_x)
            note_mismatch("pos_x", m_tdata[POS_W-1:0], want.pos_x);
          if (m_tdata[2*POS_W-1:POS_W] !== want.pos_y)
            note_mismatch("pos_y", m_tdata[2*POS_W-1:POS_W], want.pos_y);
          if (m_tdata[2*POS_W] !== want.held)
            note_mismatch("left_held", m_tdata[2*POS_W], want.held);
          if (m_tdata[2*POS_W+1] !== want.click)
            note_mismatch("left_click", m_tdata[2*POS_W+1], want.click);
          if ((m_tdata >> (2*POS_W + 2)) !== '0)
            note_mismatch("zero fill", m_tdata >> (2*POS_W + 2), 0);
        end
      end
      if (s_tvalid && s_tready)
        track_rx_byte(s_tdata);
    end
    pending = expected_moves.size();
  end

endmodule

@@ verif/tb.sv @@
// Top of the PS/2 mouse packet tracker testbench: clock, reset, byte and limit stimulus.
// Depends on pmt_pkg, ps2_mouse_packet_tracker_core and pmt_pointer_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W       = 12;
  localparam int TDATA_W     = ((2*POS_W + 2 + 7) / 8) * 8;
  // Allowance from the last packet byte to the result; wait_idle adds a margin on top.
  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PACKETS     = 65;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [pmt_pkg::RX_W-1:0]       s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [TDATA_W-1:0]             m_tdata;
  logic                           cfg_wen;
  logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pmt_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycles = 0;
  // When set, neither side idles; the last phase of the run sets it.
  bit calm = 1'b0;
  int tx_quiet = 0;

  ps2_mouse_packet_tracker_core #(.POS_WIDTH(POS_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pmt_pointer_checker #(.POS_W(POS_W), .TDATA_W(TDATA_W)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run ends far below this count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver pacing. Stalls come in random bursts, and now and then a quiet stretch
  // lets results drain at full rate. Exactly one assignment to m_tready happens
  // per falling edge.
  initial begin : result_pacing
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) stall_left = 0;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (quiet_left > 0) begin
          quiet_left--;
        end else if (!calm && !rst) begin
          if ($urandom_range(0, 99) == 0) quiet_left = $urandom_range(50, 200);
          else if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
        end
      end
    end
  end

  // Offers one byte and holds it until the transfer happens. The valid stays high
  // between back-to-back bytes; a gap, when one is drawn, drops it first.
  task automatic send_byte(input logic [pmt_pkg::RX_W-1:0] b);
    @(negedge clk);
    if (!calm) begin
      if (tx_quiet > 0) begin
        tx_quiet--;
      end else if ($urandom_range(0, 39) == 0) begin
        tx_quiet = $urandom_range(20, 120);
      end else if ($urandom_range(0, 5) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx, input logic [7:0] dy);
    send_byte(hdr);
    send_byte(dx);
    send_byte(dy);
  endtask

  // Deltas mostly random, with the sign-boundary and end values mixed in often.
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Lets every pending result drain, then waits out the pipeline so that a byte
  // still on its way (one that causes no result) is done before limits change.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic set_limits(input logic [pmt_pkg::CFG_DATA_W-1:0] xl,
                            input logic [pmt_pkg::CFG_DATA_W-1:0] yl);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= pmt_pkg::REG_X_LIMIT;
    cfg_data  <= xl;
    @(negedge clk);
    cfg_index <= pmt_pkg::REG_Y_LIMIT;
    cfg_data  <= yl;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Random traffic: mostly well-formed packets, with stray bytes and cut-short
  // packets that knock the framing out of step. A nonzero bias steers the sign
  // bits so the pointer walks into one edge of the clamp range; a positive Y bias
  // means pos_y climbs, which takes a negative dy since the Y axis is inverted.
  task automatic run_phase(input int bias_x, input int bias_y);
    logic [7:0] hdr;
    for (int p = 0; p < PACKETS; p++) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(8'($urandom_range(0, 255)) | 8'h08);
          send_byte(pick_delta());
        end
      end
      hdr = 8'($urandom_range(0, 255)) | 8'h08;
      if (bias_x != 0 && $urandom_range(0, 3) != 0) hdr[pmt_pkg::HDR_XSIGN_BIT] = (bias_x < 0);
      if (bias_y != 0 && $urandom_range(0, 3) != 0) hdr[pmt_pkg::HDR_YSIGN_BIT] = (bias_y > 0);
      send_packet(hdr, pick_delta(), pick_delta());
    end
  endtask

  function automatic int pick_bias();
    return int'($urandom_range(0, 2)) - 1;
  endfunction

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wen   = 1'b0;
    cfg_index = pmt_pkg::REG_X_LIMIT;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset limits. Two bad headers (all zero, and all
    // ones but the sync bit) must be dropped. Then: a first press gives a click,
    // a held button does not, a release, every header bit set, delta bytes of 7F and
    // 80, and overflow bits that must be ignored.
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h09, 8'h00, 8'h00);
    send_packet(8'h09, 8'hFF, 8'hFF);
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'hFF, 8'h01, 8'h80);
    send_packet(8'h08, 8'h7F, 8'h7F);
    send_packet(8'hC9, 8'h80, 8'h01);
    run_phase(pick_bias(), pick_bias());
    wait_idle();

    // Both limits at zero: every packet pins the pointer to the origin, and the
    // pointer left from the last phase is pulled in at the first packet.
    set_limits('0, '0);
    run_phase(pick_bias(), pick_bias());
    wait_idle();

    // Largest limits, with the walk pushed toward the top of both ranges.
    set_limits(12'hFFF, 12'hFFF);
    run_phase(1, 1);
    wait_idle();

    // Limits dropped well below where the pointer now sits.
    set_limits(12'd100, 12'd50);
    run_phase(pick_bias(), pick_bias());
    wait_idle();

    set_limits(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    run_phase(pick_bias(), pick_bias());
    wait_idle();

    // Last phase runs at full rate on both sides.
    set_limits(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    calm = 1'b1;
    run_phase(pick_bias(), pick_bias());
    wait_idle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pmt_pkg.sv
sv/pmt_in_stage.sv
sv/pmt_tracker.sv
sv/ps2_mouse_packet_tracker_core.sv
sv/pmt_checker.sv
verif/pmt_pointer_checker.sv
verif/tb.sv
